FILE: rtl/assert_macros.svh
// Assertion macros for the RTL of the tanh network block.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

FILE: rtl/mlp_pkg.sv
// Types, constants and tanh table for the tanh network block.
// No dependencies.
package mlp_pkg;

  localparam int unsigned MaxLayers   = 4;
  localparam int unsigned MaxWidth    = 32;
  localparam int unsigned TanhEntries = 256;

  localparam logic [2:0] CfgLayerCount = 3'd0;
  localparam logic [2:0] CfgWidth0     = 3'd1;
  localparam logic [2:0] CfgWidth3     = 3'd4;

  localparam logic ModeWrite = 1'b0;
  localparam logic ModeEval  = 1'b1;

  typedef struct packed {
    logic               mode;
    logic signed [15:0] in_u;
    logic signed [15:0] in_v;
    logic [1:0]         param_layer;
    logic [5:0]         param_row;
    logic [4:0]         param_col;
    logic signed [15:0] param_value;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] net_output;
    logic               saturated;
  } out_word_t;

  // Entry i of tanh table for the given input step, built at elaboration.
  function automatic logic [11:0] tanh_entry(int unsigned step, int unsigned i);
    longint unsigned e;
    longint unsigned k;
    longint unsigned tgt;
    longint unsigned one;
    longint unsigned num;
    longint unsigned den;
    longint unsigned quo;
    longint unsigned rem;
    e   = 64'd1 << 22;
    one = 64'd1 << 22;
    tgt = (64'(i) * 64'(step)) >> 2;
    for (k = 0; k < tgt; k++) begin
      e = (e * 64'd1075841025 + (64'd1 << 29)) >> 30;
    end
    num = (e - one) * 64'd4096 + ((e + one) >> 1);
    den = e + one;
    quo = 0;
    rem = 0;
    for (int b = 63; b >= 0; b--) begin
      rem = (rem << 1) | ((num >> b) & 64'd1);
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 64'd1;
      end
    end
    return 12'(quo);
  endfunction

endpackage

FILE: rtl/mlp_tanh.sv
// Registered tanh lookup: odd symmetric table indexed by magnitude.
// Depends on mlp_pkg.
module mlp_tanh #(
  parameter int unsigned TANH_ENTRIES = mlp_pkg::TanhEntries
) (
  input  logic               clk_i,
  input  logic signed [15:0] y_i,
  output logic signed [15:0] t_o
);
  localparam int unsigned Step   = 16384 / TANH_ENTRIES;
  localparam int unsigned IdxW   = $clog2(TANH_ENTRIES);
  localparam int unsigned ShiftW = $clog2(Step);

  logic [11:0] rom [TANH_ENTRIES];
  logic [16:0] mag;
  logic [16:0] idx;
  logic [11:0] t;
  logic signed [15:0] t_d;
  logic signed [15:0] t_q;

  for (genvar g = 0; g < TANH_ENTRIES; g++) begin : g_rom
    assign rom[g] = mlp_pkg::tanh_entry(Step, g);
  end

  always_comb begin
    mag = y_i[15] ? 17'(-$signed({y_i[15], y_i})) : 17'({1'b0, y_i});
    idx = mag >> ShiftW;
    t   = (mag >= 17'd16384 || idx >= 17'(TANH_ENTRIES)) ? 12'd4095 : rom[idx[IdxW-1:0]];
    t_d = y_i[15] ? -$signed({4'd0, t}) : $signed({4'd0, t});
  end

  always_ff @(posedge clk_i) begin
    t_q <= t_d;
  end

  assign t_o = t_q;
endmodule

FILE: rtl/mlp_tanh_inference.sv
// Top level of the tanh network block: sequencer, parameter store, activations.
// Depends on mlp_pkg, mlp_tanh and assert_macros.svh.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------
//  input    | start_i / busy_o    | in_word_i
//  config   | cfg_valid_i/ready_o | cfg_index_i, cfg_data_i
//  result   | done_o (strobe)     | out_word_o
//
// A parameter write is stored when it is accepted. An evaluation steps, for each
// output neuron of each layer, through a read and a multiply-accumulate per
// weight, a read and an add for the bias, then round, tanh and write back;
// busy_o stays high while the result strobe is shown.
// Reset clears control only; stores are undefined until written.
// Results cannot be stalled.
`include "assert_macros.svh"
module mlp_tanh_inference #(
  parameter int unsigned MAX_LAYERS   = mlp_pkg::MaxLayers,
  parameter int unsigned MAX_WIDTH    = mlp_pkg::MaxWidth,
  parameter int unsigned TANH_ENTRIES = mlp_pkg::TanhEntries
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  mlp_pkg::in_word_t in_word_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [5:0]        cfg_data_i,
  output logic              done_o,
  output mlp_pkg::out_word_t out_word_o
);
  localparam int unsigned Rows  = MAX_WIDTH + 1;
  localparam int unsigned Depth = MAX_LAYERS * Rows * MAX_WIDTH;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned NW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned XW    = $clog2(MAX_WIDTH);
  localparam int unsigned LW    = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int unsigned MaxL  = (MAX_LAYERS < 4) ? MAX_LAYERS : 4;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_READ = 7'b0000010,
    S_MAC  = 7'b0000100,
    S_BIAS = 7'b0001000,
    S_RND  = 7'b0010000,
    S_ACT  = 7'b0100000,
    S_WB   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [2:0] lcnt_q;
  logic [5:0] wid_q [4];
  logic [LW-1:0] layer_q;
  logic [XW-1:0] o_q;
  logic [NW-1:0] i_q;
  logic [NW-1:0] nin_q;
  logic sel_q;
  logic sat_q;
  logic signed [47:0] acc_q;
  logic signed [15:0] y_q;
  logic done_q;
  logic signed [15:0] res_q;
  logic res_sat_q;

  logic signed [15:0] pmem [Depth];
  logic signed [15:0] abuf [2][MAX_WIDTH];
  logic signed [15:0] p_rd_q, a_rd_q;
  logic signed [15:0] tanh_y;

  logic [2:0] nl;
  logic [NW-1:0] nout;
  logic [5:0] wsel;
  logic [NW-1:0] rrow;
  logic [AW-1:0] raddr;
  logic last_layer;
  logic accept;

  always_comb begin
    nl = (lcnt_q == 3'd0) ? 3'd1 : ((32'(lcnt_q) > MaxL) ? 3'(MaxL) : lcnt_q);
    wsel = wid_q[2'(layer_q)];
    if (wsel == 6'd0) nout = NW'(1);
    else if (32'(wsel) > MAX_WIDTH) nout = NW'(MAX_WIDTH);
    else nout = NW'(wsel);
    last_layer = (32'(layer_q) + 1 >= 32'(nl));
    rrow = (i_q == nin_q) ? NW'(MAX_WIDTH) : i_q;
    raddr = AW'((32'(layer_q) * Rows + 32'(rrow)) * MAX_WIDTH + 32'(o_q));
    accept = start_i && !busy_o;
  end

  // Parameter store: write port for loads, one read port for the sequencer.
  always_ff @(posedge clk_i) begin
    if (accept && in_word_i.mode == mlp_pkg::ModeWrite &&
        32'(in_word_i.param_layer) < MAX_LAYERS &&
        32'(in_word_i.param_row) <= MAX_WIDTH && 32'(in_word_i.param_col) < MAX_WIDTH) begin
      pmem[AW'((32'(in_word_i.param_layer) * Rows + 32'(in_word_i.param_row)) * MAX_WIDTH
               + 32'(in_word_i.param_col))] <= in_word_i.param_value;
    end
    p_rd_q <= pmem[raddr];
  end

  // Activation buffers: ping-pong, read current, write next.
  always_ff @(posedge clk_i) begin
    if (accept && in_word_i.mode == mlp_pkg::ModeEval) begin
      abuf[0][0] <= in_word_i.in_u;
      abuf[0][1] <= in_word_i.in_v;
    end else if (state_q == S_WB) begin
      abuf[!sel_q][o_q] <= (last_layer) ? y_q : tanh_y;
    end
    a_rd_q <= abuf[sel_q][i_q[XW-1:0]];
  end

  mlp_tanh #(.TANH_ENTRIES(TANH_ENTRIES)) u_tanh (
    .clk_i(clk_i), .y_i(y_q), .t_o(tanh_y)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept && in_word_i.mode == mlp_pkg::ModeEval) state_d = S_READ;
      S_READ: state_d = S_MAC;
      S_MAC:  state_d = (i_q == nin_q) ? S_BIAS : S_READ;
      S_BIAS: state_d = S_RND;
      S_RND:  state_d = S_ACT;
      S_ACT:  state_d = S_WB;
      S_WB:   state_d = ((32'(o_q) + 1 >= 32'(nout)) && last_layer) ? S_IDLE : S_READ;
      default: state_d = S_IDLE;
    endcase
  end

  logic signed [47:0] rnd;
  always_comb rnd = (acc_q + 48'sd2048) >>> 12;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lcnt_q  <= 3'd1;
      for (int k = 0; k < 4; k++) wid_q[k] <= 6'd1;
      layer_q <= '0;
      o_q <= '0;
      i_q <= '0;
      nin_q <= '0;
      sel_q <= 1'b0;
      sat_q <= 1'b0;
      acc_q <= '0;
      y_q <= '0;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == mlp_pkg::CfgLayerCount) lcnt_q <= cfg_data_i[2:0];
        else if (cfg_index_i inside {[mlp_pkg::CfgWidth0:mlp_pkg::CfgWidth3]})
          wid_q[2'(cfg_index_i - mlp_pkg::CfgWidth0)] <= cfg_data_i;
      end
      case (state_q)
        S_IDLE: begin
          layer_q <= '0; o_q <= '0; i_q <= '0;
          nin_q <= NW'(2); sel_q <= 1'b0; sat_q <= 1'b0;
          acc_q <= '0;
        end
        S_READ: ;
        S_MAC: begin
          if (i_q != nin_q) begin
            acc_q <= acc_q + 48'(p_rd_q * a_rd_q);
            i_q <= i_q + NW'(1);
          end
        end
        S_BIAS: acc_q <= acc_q + (48'(p_rd_q) <<< 12);
        S_RND: begin
          if (rnd > 48'sd32767) begin y_q <= 16'sh7fff; sat_q <= 1'b1; end
          else if (rnd < -48'sd32768) begin y_q <= -16'sh8000; sat_q <= 1'b1; end
          else y_q <= 16'(rnd);
        end
        S_ACT: ;
        S_WB: begin
          acc_q <= '0;
          i_q <= '0;
          if (32'(o_q) + 1 >= 32'(nout)) begin
            o_q <= '0;
            if (last_layer) begin
              done_q <= 1'b1;
            end else begin
              layer_q <= layer_q + LW'(1);
              nin_q <= nout;
              sel_q <= !sel_q;
            end
          end else begin
            o_q <= o_q + XW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Result hold: capture neuron 0 of the last layer, and the saturation flag at every write back.
  always_ff @(posedge clk_i) begin
    if (state_q == S_WB && last_layer && o_q == '0) res_q <= y_q;
    if (state_q == S_WB) res_sat_q <= sat_q;
  end

  assign busy_o = (state_q != S_IDLE) || done_q;
  assign cfg_ready_o = !busy_o;
  assign done_o = done_q;
  assign out_word_o.net_output = res_q;
  assign out_word_o.saturated = res_sat_q;

  `ASSERT_NEXT(a_eval_busy, clk_i, rst_ni, accept && in_word_i.mode == mlp_pkg::ModeEval, busy_o)
  `ASSERT_IMPL(a_done_idle, clk_i, rst_ni, done_q, state_q == S_IDLE)
  `ASSERT_IMPL(a_onehot, clk_i, rst_ni, 1'b1, $onehot(state_q))
  `ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, done_q, !done_q)
endmodule

FILE: dv/mlp_checker.sv
// Scoreboard for the tanh network block: watches the input, config and result channels.
// Predicts each evaluation from its own parameter store and tanh table; depends on mlp_pkg.
`timescale 1ns / 100ps
module mlp_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_o,
  input  mlp_pkg::in_word_t  in_word_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [5:0]         cfg_data_i,
  input  logic               done_o,
  input  mlp_pkg::out_word_t out_word_o,
  output int                 errors_o,
  output int                 pending_o
);
  logic signed [15:0] weight_store [mlp_pkg::MaxLayers][mlp_pkg::MaxWidth+1][mlp_pkg::MaxWidth];
  int                 tanh_rom [mlp_pkg::TanhEntries];
  logic [2:0]         layer_count;
  logic [5:0]         layer_width [4];
  mlp_pkg::out_word_t expected_q [$];

  initial begin
    longint unsigned e;
    longint unsigned k;
    longint unsigned tgt;
    e = 64'd1 << 22;
    k = 0;
    for (int i = 0; i < mlp_pkg::TanhEntries; i++) begin
      tgt = (64'(i) * 64'(16384 / mlp_pkg::TanhEntries)) >> 2;
      while (k < tgt) begin
        e = (e * 64'd1075841025 + (64'd1 << 29)) >> 30;
        k++;
      end
      tanh_rom[i] = int'(((e - (64'd1 << 22)) * 64'd4096 + (e + (64'd1 << 22)) / 64'd2)
                         / (e + (64'd1 << 22)));
    end
  end

  function automatic int tanh_q12(int y);
    int mag;
    int t;
    mag = (y < 0) ? -y : y;
    t = (mag >= 16384) ? 4095 : tanh_rom[mag / (16384 / mlp_pkg::TanhEntries)];
    return (y < 0) ? -t : t;
  endfunction

  function automatic mlp_pkg::out_word_t forward_pass(mlp_pkg::in_word_t w);
    int                 act [mlp_pkg::MaxWidth];
    int                 nxt [mlp_pkg::MaxWidth];
    int                 nl;
    int                 n_in;
    int                 n_out;
    longint             acc;
    longint             y;
    mlp_pkg::out_word_t r;
    r.saturated = 1'b0;
    nl = (layer_count == 0) ? 1 : (layer_count > 4) ? 4 : layer_count;
    act[0] = w.in_u;
    act[1] = w.in_v;
    n_in = 2;
    for (int l = 0; l < nl; l++) begin
      n_out = (layer_width[l] == 0) ? 1 : (layer_width[l] > mlp_pkg::MaxWidth) ?
              mlp_pkg::MaxWidth : layer_width[l];
      for (int o = 0; o < n_out; o++) begin
        acc = longint'(weight_store[l][mlp_pkg::MaxWidth][o]) * 4096;
        for (int i = 0; i < n_in; i++) acc += longint'(weight_store[l][i][o]) * act[i];
        y = (acc + 2048) >>> 12;
        if (y > 32767) begin
          y = 32767;
          r.saturated = 1'b1;
        end else if (y < -32768) begin
          y = -32768;
          r.saturated = 1'b1;
        end
        nxt[o] = (l + 1 < nl) ? tanh_q12(int'(y)) : int'(y);
      end
      act = nxt;
      n_in = n_out;
    end
    r.net_output = 16'(act[0]);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int exp);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, exp);
    errors_o++;
  endtask

  always @(posedge clk_i) begin
    mlp_pkg::out_word_t exp;
    if (!rst_ni) begin
      layer_count = 3'd1;
      for (int i = 0; i < 4; i++) layer_width[i] = 6'd1;
      expected_q.delete();
      errors_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == mlp_pkg::CfgLayerCount) layer_count = cfg_data_i[2:0];
        else if (cfg_index_i inside {[mlp_pkg::CfgWidth0:mlp_pkg::CfgWidth3]})
          layer_width[2'(cfg_index_i - mlp_pkg::CfgWidth0)] = cfg_data_i;
      end
      if (start_i && !busy_o) begin
        if (in_word_i.mode == mlp_pkg::ModeWrite) begin
          if (in_word_i.param_row <= mlp_pkg::MaxWidth)
            weight_store[in_word_i.param_layer][in_word_i.param_row][in_word_i.param_col] =
              in_word_i.param_value;
        end else begin
          expected_q.push_back(forward_pass(in_word_i));
        end
      end
      if (done_o) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected word", out_word_o.net_output, 0);
        end else begin
          exp = expected_q.pop_front();
          if (out_word_o.net_output !== exp.net_output)
            report_mismatch("net_output", out_word_o.net_output, exp.net_output);
          if (out_word_o.saturated !== exp.saturated)
            report_mismatch("saturated", out_word_o.saturated, exp.saturated);
        end
      end
    end
    pending_o = expected_q.size();
  end
endmodule

FILE: dv/tb.sv
// Top of the tanh network testbench: clock, reset, stimulus and verdict.
// Depends on mlp_pkg, mlp_tanh_inference and mlp_checker.
`timescale 1ns / 100ps
module tb;
  localparam logic [2:0] CfgUnused = 3'd7;
  localparam int         Limit     = 4000000;

  logic      clk_i;
  logic      rst_ni;
  logic      start_i;
  logic      busy_o;
  mlp_pkg::in_word_t  in_word_i;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic [2:0] cfg_index_i;
  logic [5:0] cfg_data_i;
  logic      done_o;
  mlp_pkg::out_word_t out_word_o;
  int        errors;
  int        pending;
  int        cycles = 0;
  int        idle_pct;
  logic      took;
  logic      cfg_took;
  bit        written [mlp_pkg::MaxLayers][mlp_pkg::MaxWidth+1][mlp_pkg::MaxWidth];
  logic [2:0] shadow_count;
  logic [5:0] shadow_width [4];

  mlp_tanh_inference i_dut (.*);

  mlp_checker i_checker (
    .clk_i, .rst_ni, .start_i, .busy_o, .in_word_i, .cfg_valid_i, .cfg_ready_o,
    .cfg_index_i, .cfg_data_i, .done_o, .out_word_o,
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    took     <= start_i && !busy_o;
    cfg_took <= cfg_valid_i && cfg_ready_o;
    cycles   <= cycles + 1;
    if (cycles > Limit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic signed [15:0] rand_q12();
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'(int'($urandom_range(8191)) - 4096);
  endfunction

  function automatic mlp_pkg::in_word_t rand_word();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(mlp_pkg::in_word_t)-1:0];
  endfunction

  function automatic int eff_width(int l);
    return (shadow_width[l] == 0) ? 1 : (shadow_width[l] > mlp_pkg::MaxWidth) ?
           mlp_pkg::MaxWidth : shadow_width[l];
  endfunction

  task automatic send_word(mlp_pkg::in_word_t w);
    if ($urandom_range(99) < idle_pct) begin
      start_i = 1'b0;
      while ($urandom_range(99) < idle_pct) @(negedge clk_i);
      @(negedge clk_i);
    end
    start_i   = 1'b1;
    in_word_i = w;
    do @(negedge clk_i); while (!took);
    if (w.mode == mlp_pkg::ModeWrite && w.param_row <= mlp_pkg::MaxWidth)
      written[w.param_layer][w.param_row][w.param_col] = 1'b1;
  endtask

  task automatic write_param(int l, int r, int c, logic signed [15:0] v);
    mlp_pkg::in_word_t w;
    w = rand_word();
    w.mode        = mlp_pkg::ModeWrite;
    w.param_layer = 2'(l);
    w.param_row   = 6'(r);
    w.param_col   = 5'(c);
    w.param_value = v;
    send_word(w);
  endtask

  task automatic evaluate(logic signed [15:0] u, logic signed [15:0] v);
    int                nl;
    int                n_in;
    mlp_pkg::in_word_t w;
    nl = (shadow_count == 0) ? 1 : (shadow_count > 4) ? 4 : shadow_count;
    n_in = 2;
    for (int l = 0; l < nl; l++) begin
      for (int o = 0; o < eff_width(l); o++)
        for (int r = 0; r <= mlp_pkg::MaxWidth; r++)
          if ((r < n_in || r == mlp_pkg::MaxWidth) && !written[l][r][o])
            write_param(l, r, o, rand_q12());
      n_in = eff_width(l);
    end
    w = rand_word();
    w.mode = mlp_pkg::ModeEval;
    w.in_u = u;
    w.in_v = v;
    send_word(w);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [5:0] data);
    start_i = 1'b0;
    while (pending != 0 || busy_o) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(negedge clk_i); while (!cfg_took);
    cfg_valid_i = 1'b0;
    if (idx == mlp_pkg::CfgLayerCount) shadow_count = data[2:0];
    else if (idx <= mlp_pkg::CfgWidth3) shadow_width[2'(idx - mlp_pkg::CfgWidth0)] = data;
  endtask

  task automatic set_network(int lc, int w0, int w1, int w2, int w3);
    cfg_write(mlp_pkg::CfgLayerCount, 6'(lc));
    cfg_write(mlp_pkg::CfgWidth0, 6'(w0));
    cfg_write(mlp_pkg::CfgWidth0 + 3'd1, 6'(w1));
    cfg_write(mlp_pkg::CfgWidth0 + 3'd2, 6'(w2));
    cfg_write(mlp_pkg::CfgWidth3, 6'(w3));
  endtask

  initial begin
    mlp_pkg::in_word_t w;
    int       lc [7] = '{2, 4, 3, 0, 7, 1, 4};
    int       wd [7][4] = '{'{3, 2, 1, 1}, '{1, 32, 1, 1}, '{3, 1, 2, 1}, '{0, 63, 5, 5},
                            '{4, 3, 2, 1}, '{1, 1, 1, 1}, '{3, 4, 2, 5}};
    int       idle [7] = '{0, 71, 0, 13, 13, 71, 0};
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    in_word_i    = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    idle_pct     = 0;
    shadow_count = 3'd1;
    for (int i = 0; i < 4; i++) shadow_width[i] = 6'd1;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    set_network(2, 1, 1, 1, 1);
    cfg_write(CfgUnused, 6'h3f);
    write_param(0, 0, 0, 16'sh7fff);
    write_param(0, 1, 0, 16'sh7fff);
    write_param(0, mlp_pkg::MaxWidth, 0, -16'sh8000);
    write_param(1, 0, 0, 16'sh1000);
    write_param(1, mlp_pkg::MaxWidth, 0, 16'sh0000);
    write_param(3, 33, 31, 16'sh7fff);
    write_param(3, 63, 31, -16'sh8000);
    evaluate(-16'sh8000, -16'sh8000);
    evaluate(16'sh7fff, 16'sh7fff);
    evaluate(16'sh0000, 16'sh0000);
    evaluate(-16'sh8000, 16'sh7fff);
    write_param(0, mlp_pkg::MaxWidth, 0, 16'sh7fff);
    evaluate(16'sh7fff, -16'sh8000);
    write_param(1, 0, 0, -16'sh8000);
    write_param(1, mlp_pkg::MaxWidth, 0, -16'sh8000);
    evaluate(16'sh1234, -16'sh0567);

    for (int p = 0; p < 7; p++) begin
      set_network(lc[p], wd[p][0], wd[p][1], wd[p][2], wd[p][3]);
      idle_pct = idle[p];
      for (int n = 0; n < 20; n++) begin
        case ($urandom_range(9))
          0: begin
            w = rand_word();
            w.mode = mlp_pkg::ModeWrite;
            send_word(w);
          end
          1, 2, 3:
            write_param($urandom_range(3),
                        $urandom_range(2) == 0 ? mlp_pkg::MaxWidth : $urandom_range(3),
                        $urandom_range(3), rand_q12());
          default: evaluate(16'($urandom), 16'($urandom));
        endcase
      end
    end

    start_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
